[hw/rtl/bdq_pkg.sv]
// Package for the bounded deque: sizes, payload types, operation and status codes,
// and the circular slot arithmetic.
// No dependencies; every other file in hw/rtl but bdq_ram imports it.
package bdq_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int MODE_W     = 3;
   localparam int IO_W       = 32;
   localparam int POS_W      = 4;
   localparam int CNT_OUT_W  = 5;
   localparam int STAT_W     = 2;

   typedef logic [DATA_WIDTH-1:0] data_type;
   typedef logic [ADDR_W-1:0]     addr_type;
   typedef logic [CNT_W-1:0]      cnt_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH_FRONT = 3'd0,
      MODE_PUSH_BACK  = 3'd1,
      MODE_POP_FRONT  = 3'd2,
      MODE_POP_BACK   = 3'd3,
      MODE_SEARCH     = 3'd4,
      MODE_SIZE       = 3'd5
   } mode_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } stat_type;

   typedef struct packed {
      logic signed [IO_W-1:0] value_out;
      logic                   found;
      logic [POS_W-1:0]       position;
      logic [CNT_OUT_W-1:0]   count;
      stat_type               status;
   } rsp_type;

   typedef struct packed {
      logic     we;
      addr_type waddr;
      data_type wdata;
      logic     re;
      addr_type raddr;
   } ram_req_type;

   // slot that lies off places behind base, wrapping at DEPTH
   function automatic addr_type slot(input addr_type base, input addr_type off);
      logic [ADDR_W:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= (ADDR_W + 1)'(DEPTH)) begin
         sum = sum - (ADDR_W + 1)'(DEPTH);
      end
      return sum[ADDR_W-1:0];
   endfunction

endpackage

[hw/rtl/bdq_if.sv]
// Valid/ready channel interfaces for the deque: request beats and response beats.
// Depends on bdq_pkg for field widths.
interface bdq_req_if;
   import bdq_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [MODE_W-1:0]      mode;
   logic signed [IO_W-1:0] value_in;

   modport source (output valid, output mode, output value_in, input ready);
   modport sink   (input valid, input mode, input value_in, output ready);
endinterface

interface bdq_rsp_if;
   import bdq_pkg::*;
   logic                   valid;
   logic                   ready;
   logic signed [IO_W-1:0] value_out;
   logic                   found;
   logic [POS_W-1:0]       position;
   logic [CNT_OUT_W-1:0]   count;
   logic [STAT_W-1:0]      status;

   modport source (output valid, output value_out, output found, output position,
                   output count, output status, input ready);
   modport sink   (input valid, input value_out, input found, input position,
                   input count, input status, output ready);
endinterface

[hw/rtl/bounded_deque_with_search.sv]
// Bounded deque with search. A push or size query responds from the execute state; a pop
// reads the RAM and responds from its wait state, or at once on an empty deque. A search
// reads one entry per cycle through the single RAM read port and responds on a hit or
// once every held entry is compared. The next request beat is taken the cycle after the
// response is registered. Reset (synchronous) empties the deque and drops any pending
// response; the entry RAM is left as is, since only held entries are ever read.
module bounded_deque_with_search (
   input  logic      clock,
   input  logic      reset,
   bdq_req_if.sink   req_if,
   bdq_rsp_if.source rsp_if
);
   import bdq_pkg::*;

   ram_req_type ram_req;
   data_type    ram_rdata;

   // sequencer: owns front pointer, fill count and response register
   bdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .ram_req   (ram_req),
      .ram_rdata (ram_rdata)
   );

   // entry storage, one write and one registered read per cycle
   bdq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_req.we),
      .waddr (ram_req.waddr),
      .wdata (ram_req.wdata),
      .re    (ram_req.re),
      .raddr (ram_req.raddr),
      .rdata (ram_rdata)
   );

   // a rejected push only happens at full occupancy
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && (rsp_if.status == STAT_FULL)) |-> (rsp_if.count == CNT_OUT_W'(DEPTH)))
      else $error("full status with count below depth");

   // a failed pop reports an empty deque and no data
   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && (rsp_if.status == STAT_EMPTY)) |->
      ((rsp_if.count == '0) && (rsp_if.value_out == '0)))
      else $error("empty status with nonzero count or data");

   // a miss carries no position
   a_miss_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.found) |-> (rsp_if.position == '0))
      else $error("position set without a match");

   // the sequencer never writes and reads the RAM in the same cycle
   a_ram_excl: assert property (@(posedge clock) disable iff (reset)
      !(ram_req.we && ram_req.re))
      else $error("RAM write and read issued together");
endmodule

[hw/rtl/bdq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem[raddr];
      end
   end
endmodule

[hw/rtl/bdq_ctrl.sv]
// Deque sequencer: front pointer, fill count, search scan and response register.
// Depends on bdq_pkg and bdq_if; drives the entry RAM through a ram_req_type struct.
module bdq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   bdq_req_if.sink              req,
   bdq_rsp_if.source            rsp,
   output bdq_pkg::ram_req_type ram_req,
   input  bdq_pkg::data_type    ram_rdata
);
   import bdq_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_POP_WT,
      ST_SRCH,
      ST_FIN
   } state_type;

   state_type state_ff, state_in;
   mode_type  op_ff, op_in;
   data_type  key_ff, key_in;
   addr_type  front_ff, front_in;
   cnt_type   cnt_ff, cnt_in;
   cnt_type   iss_ff, iss_in;
   logic      chk_vld_ff, chk_vld_in;
   addr_type  chk_idx_ff, chk_idx_in;
   rsp_type   res_ff, res_in;
   logic      rsp_vld_ff, rsp_vld_in;
   rsp_type   rsp_dat_ff, rsp_dat_in;

   rsp_type   res;
   logic      done;
   logic      slot_free;
   logic      load;

   assign slot_free = !rsp_vld_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      key_in     = key_ff;
      front_in   = front_ff;
      cnt_in     = cnt_ff;
      iss_in     = iss_ff;
      chk_vld_in = chk_vld_ff;
      chk_idx_in = chk_idx_ff;
      res_in     = res_ff;
      done       = 1'b0;
      res        = '0;
      res.status = STAT_OK;
      res.count  = CNT_OUT_W'(cnt_ff);
      ram_req       = '0;
      ram_req.wdata = key_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               op_in    = mode_type'(req.mode);
               key_in   = DATA_WIDTH'($unsigned(req.value_in));
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (op_ff)
               MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                  done = 1'b1;
                  if (cnt_ff == CNT_W'(DEPTH)) begin
                     res.status = STAT_FULL;
                  end else begin
                     ram_req.we = 1'b1;
                     if (op_ff == MODE_PUSH_FRONT) begin
                        ram_req.waddr = (front_ff == '0) ? ADDR_W'(DEPTH - 1)
                                                         : front_ff - 1'b1;
                        front_in = ram_req.waddr;
                     end else begin
                        ram_req.waddr = slot(front_ff, ADDR_W'(cnt_ff));
                     end
                     cnt_in    = cnt_ff + 1'b1;
                     res.count = CNT_OUT_W'(cnt_ff + 1'b1);
                  end
               end
               MODE_POP_FRONT, MODE_POP_BACK: begin
                  if (cnt_ff == '0) begin
                     done       = 1'b1;
                     res.status = STAT_EMPTY;
                  end else begin
                     ram_req.re = 1'b1;
                     if (op_ff == MODE_POP_FRONT) begin
                        ram_req.raddr = front_ff;
                        front_in      = slot(front_ff, ADDR_W'(1));
                     end else begin
                        ram_req.raddr = slot(front_ff, ADDR_W'(cnt_ff - 1'b1));
                     end
                     cnt_in   = cnt_ff - 1'b1;
                     state_in = ST_POP_WT;
                  end
               end
               MODE_SEARCH: begin
                  iss_in     = '0;
                  chk_vld_in = 1'b0;
                  state_in   = ST_SRCH;
               end
               default: begin
                  done = 1'b1;
               end
            endcase
         end
         ST_POP_WT: begin
            done          = 1'b1;
            res.value_out = IO_W'(signed'(ram_rdata));
         end
         ST_SRCH: begin
            // compare the entry read last cycle while the next read goes out
            if (chk_vld_ff && (ram_rdata == key_ff)) begin
               done         = 1'b1;
               res.found    = 1'b1;
               res.position = POS_W'(chk_idx_ff);
            end else if (iss_ff == cnt_ff) begin
               done = 1'b1;
            end else begin
               ram_req.re    = 1'b1;
               ram_req.raddr = slot(front_ff, ADDR_W'(iss_ff));
               chk_vld_in    = 1'b1;
               chk_idx_in    = ADDR_W'(iss_ff);
               iss_in        = iss_ff + 1'b1;
            end
         end
         ST_FIN: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (done) begin
         res_in   = res;
         state_in = slot_free ? ST_IDLE : ST_FIN;
      end
   end

   assign load       = (done || (state_ff == ST_FIN)) && slot_free;
   assign rsp_dat_in = done ? res : res_ff;
   assign rsp_vld_in = load ? 1'b1 : (rsp.ready ? 1'b0 : rsp_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         front_ff   <= '0;
         cnt_ff     <= '0;
         chk_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         front_ff   <= front_in;
         cnt_ff     <= cnt_in;
         chk_vld_ff <= chk_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      op_ff      <= op_in;
      key_ff     <= key_in;
      iss_ff     <= iss_in;
      chk_idx_ff <= chk_idx_in;
      res_ff     <= res_in;
      if (load) begin
         rsp_dat_ff <= rsp_dat_in;
      end
   end

   assign rsp.valid     = rsp_vld_ff;
   assign rsp.value_out = rsp_dat_ff.value_out;
   assign rsp.found     = rsp_dat_ff.found;
   assign rsp.position  = rsp_dat_ff.position;
   assign rsp.count     = rsp_dat_ff.count;
   assign rsp.status    = rsp_dat_ff.status;
endmodule
